// File: hw/rtl/dmrt_pkg.sv
// Shared types and codes for the direct-mapped result table.
package dmrt_pkg;

	localparam logic OP_PROBE = 1'b0;
	localparam logic OP_STORE = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [63:0] key_hash;
		logic [7:0]  search_depth;
		logic [63:0] store_count;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] found_count;
		logic [63:0] hit_total;
		logic [63:0] miss_total;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [7:0]  depth;
		logic [63:0] count;
	} entry_t;

endpackage

// File: hw/rtl/dmrt_mem.sv
// Entry store: one write port, one read port with registered read data.
module dmrt_mem #(
	parameter int INDEX_BITS = 12
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [INDEX_BITS-1:0] waddr,
	input  dmrt_pkg::entry_t      wdata,
	input  logic                  re,
	input  logic [INDEX_BITS-1:0] raddr,
	output dmrt_pkg::entry_t      rdata
);

	localparam int Depth = 1 << INDEX_BITS;

	dmrt_pkg::entry_t mem [Depth];
	dmrt_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/dmrt_sweep.sv
// Post-reset sweep that clears every entry's valid bit, one entry a cycle.
module dmrt_sweep #(
	parameter int INDEX_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	output logic                  busy,
	output logic [INDEX_BITS-1:0] addr
);

	logic [INDEX_BITS-1:0] addr_q;
	logic                  done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			done_q <= 1'b0;
		end else if (!done_q) begin
			addr_q <= addr_q + 1'b1;
			if (addr_q == {INDEX_BITS{1'b1}}) begin
				done_q <= 1'b1;
			end
		end
	end

	assign busy = !done_q;
	assign addr = addr_q;

endmodule

// File: hw/rtl/dmrt_lookup.sv
// Compare stage, hit/miss counters and the response register.
module dmrt_lookup (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  dmrt_pkg::req_t   req,
	input  dmrt_pkg::entry_t rdata,
	output logic             room,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dmrt_pkg::rsp_t   rsp
);

	logic        valid_s1;
	logic        op_s1;
	logic [63:0] key_s1;
	logic [7:0]  depth_s1;

	logic [63:0]    hit_q;
	logic [63:0]    miss_q;
	logic           rsp_valid_q;
	dmrt_pkg::rsp_t rsp_q;

	logic        move;
	logic        hit_c;
	logic [63:0] hit_nxt;
	logic [63:0] miss_nxt;

	assign move = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign room = !valid_s1 || move;

	// A probe hits on a valid entry holding the same key and depth.
	assign hit_c = (op_s1 == dmrt_pkg::OP_PROBE) && rdata.valid &&
		(rdata.key == key_s1) && (rdata.depth == depth_s1);

	always_comb begin
		hit_nxt  = hit_q;
		miss_nxt = miss_q;
		if (op_s1 == dmrt_pkg::OP_PROBE) begin
			if (hit_c) begin
				hit_nxt = hit_q + 64'd1;
			end else begin
				miss_nxt = miss_q + 64'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hit_q       <= '0;
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				hit_q       <= hit_nxt;
				miss_q      <= miss_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= req.operation;
			key_s1   <= req.key_hash;
			depth_s1 <= req.search_depth;
		end
		if (move) begin
			rsp_q.hit         <= hit_c;
			rsp_q.found_count <= hit_c ? rdata.count : 64'd0;
			rsp_q.hit_total   <= hit_nxt;
			rsp_q.miss_total  <= miss_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hw/rtl/direct_mapped_result_table_unit.sv
// Direct-mapped result table: top level wiring memory, sweep and lookup.
// The table holds 2^INDEX_BITS entries in one synchronous memory, indexed by the
// low INDEX_BITS bits of key_hash. After reset a sweep clears the valid bit of
// every entry, one entry a cycle, and req_stall stays high until the sweep is done.
// After that the block takes one request per clock unless a stalled response
// backs it up: a store writes its entry at the edge it is accepted, a probe reads
// the entry at the same edge and compares in the next cycle, and the response
// is loaded into the output register when the compare stage moves on. A store's
// result reaches the memory before the next request's read, so no forwarding is
// needed. Every request yields exactly one response carrying both wrapping
// counters.
module direct_mapped_result_table_unit #(
	parameter int INDEX_BITS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dmrt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dmrt_pkg::rsp_t rsp
);

	logic                  sweep_busy;
	logic [INDEX_BITS-1:0] sweep_addr;
	logic                  room;
	logic                  take;
	logic [INDEX_BITS-1:0] idx;

	logic                  mem_we;
	logic                  mem_re;
	logic [INDEX_BITS-1:0] mem_waddr;
	dmrt_pkg::entry_t      mem_wdata;
	dmrt_pkg::entry_t      mem_rdata;

	// No transfer while the sweep runs or the compare stage cannot drain.
	assign req_stall = sweep_busy || !room;
	assign take      = req_valid && !req_stall;
	assign idx       = req.key_hash[INDEX_BITS-1:0];

	// The sweep owns the write port until it finishes; then stores use it.
	assign mem_we    = sweep_busy || (take && (req.operation == dmrt_pkg::OP_STORE));
	assign mem_waddr = sweep_busy ? sweep_addr : idx;
	always_comb begin
		mem_wdata = '0;
		if (!sweep_busy) begin
			mem_wdata.valid = 1'b1;
			mem_wdata.key   = req.key_hash;
			mem_wdata.depth = req.search_depth;
			mem_wdata.count = req.store_count;
		end
	end

	// Only probes need the stored entry.
	assign mem_re = take && (req.operation == dmrt_pkg::OP_PROBE);

	dmrt_sweep #(
		.INDEX_BITS(INDEX_BITS)
	) u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.busy  (sweep_busy),
		.addr  (sweep_addr)
	);

	dmrt_mem #(
		.INDEX_BITS(INDEX_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(idx),
		.rdata(mem_rdata)
	);

	dmrt_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.req      (req),
		.rdata    (mem_rdata),
		.room     (room),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// File: hw/rtl/dmrt_checker.sv
// Port-level checks for the result table, bound to the top level.
module dmrt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input dmrt_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.found_count == 64'd0)
		else $error("found_count non-zero without a hit");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && $past(rsp_valid && !rsp_stall) && rsp.hit |->
			rsp.hit_total == $past(rsp.hit_total) + 64'd1)
		else $error("hit_total did not step on a hit");

	a_hit_no_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && $past(rsp_valid && !rsp_stall) && rsp.hit |->
			rsp.miss_total == $past(rsp.miss_total))
		else $error("miss_total moved on a hit");

endmodule

bind direct_mapped_result_table_unit dmrt_checker u_dmrt_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the direct-mapped result table unit.
module testbench;

	localparam int          INDEX_BITS = 12;
	localparam logic [63:0] SLOT_MASK  = (64'h1 << INDEX_BITS) - 64'h1;
	// Worst case: the clearing sweep, 1546 transfers each waiting out
	// a sender gap and a heavy receiver stall, plus the long hold-off.
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          RANDOM_ITEMS = 1525;

	// Shadow copy of the table: works out the response each accepted request
	// must produce and keeps those responses in order until they come out.
	class result_table_shadow;
		localparam int IDX_W = INDEX_BITS;
		localparam int SLOTS = 1 << IDX_W;

		bit               slot_valid [SLOTS];
		logic [63:0]      slot_key   [SLOTS];
		logic [7:0]       slot_depth [SLOTS];
		logic [63:0]      slot_count [SLOTS];
		logic [63:0]      probe_hits;
		logic [63:0]      probe_misses;
		dmrt_pkg::rsp_t   due_responses [$];
		int               failures;

		function new();
			probe_hits   = '0;
			probe_misses = '0;
			failures     = 0;
		endfunction

		function void apply_request(dmrt_pkg::req_t r);
			dmrt_pkg::rsp_t   want;
			logic [IDX_W-1:0] slot;
			want = '0;
			slot = r.key_hash[IDX_W-1:0];
			if (r.operation == dmrt_pkg::OP_STORE) begin
				slot_valid[slot] = 1'b1;
				slot_key[slot]   = r.key_hash;
				slot_depth[slot] = r.search_depth;
				slot_count[slot] = r.store_count;
			end else if (slot_valid[slot] && slot_key[slot] == r.key_hash &&
					slot_depth[slot] == r.search_depth) begin
				want.hit         = 1'b1;
				want.found_count = slot_count[slot];
				probe_hits       = probe_hits + 64'd1;
			end else begin
				probe_misses = probe_misses + 64'd1;
			end
			want.hit_total  = probe_hits;
			want.miss_total = probe_misses;
			due_responses = {due_responses, want};
		endfunction

		function void check_response(dmrt_pkg::rsp_t got);
			dmrt_pkg::rsp_t want;
			if (due_responses.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response: hit %0b found %h hits %0d misses %0d",
						got.hit, got.found_count, got.hit_total, got.miss_total);
				return;
			end
			want = due_responses.pop_front();
			if (got.hit !== want.hit || got.found_count !== want.found_count ||
					got.hit_total !== want.hit_total ||
					got.miss_total !== want.miss_total) begin
				failures++;
				if (failures <= 10) begin
					$display("response mismatch (expected / actual):");
					$display("  hit %0b / %0b  found %h / %h", want.hit, got.hit,
						want.found_count, got.found_count);
					$display("  hits %0d / %0d  misses %0d / %0d", want.hit_total,
						got.hit_total, want.miss_total, got.miss_total);
				end
			end
		endfunction

		function int pending();
			return due_responses.size();
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	dmrt_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	dmrt_pkg::rsp_t rsp;

	result_table_shadow shadow = new();

	// Recently stored keys and depths; most probes are drawn from these so
	// that they land on entries already written.
	logic [63:0] stored_keys   [$];
	logic [7:0]  stored_depths [$];

	// Hand-shake between the main sequence and the receiver for the long
	// hold-off: the sender keeps offering with no gaps while it lasts.
	bit hold_off_ask;
	bit hold_off_active;

	int unsigned cycle_count;

	direct_mapped_result_table_unit #(
		.INDEX_BITS(INDEX_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Result side: every response transfer is checked against the oldest
	// expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
			shadow.check_response(rsp);
	end

	// Receiver: stalls in segments of differing character (none, light,
	// heavy, periodic), and on request holds off for a long stretch so the
	// table backs up and stalls its request side.
	initial begin
		int mode;
		int seg_len;
		int tick;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(16, 96);
			repeat (seg_len) begin
				@(negedge clk);
				tick++;
				if (hold_off_ask) begin
					hold_off_ask    = 1'b0;
					hold_off_active = 1'b1;
					rsp_stall <= 1'b1;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_active = 1'b0;
				end else begin
					case (mode)
						0: rsp_stall <= 1'b0;
						1: rsp_stall <= ($urandom_range(0, 3) == 0);
						2: rsp_stall <= ($urandom_range(0, 3) != 0);
						default: rsp_stall <= (tick % 3 == 0);
					endcase
				end
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Present one request from the falling edge and hold it until a rising
	// edge takes it; returns at the following falling edge.
	task automatic send_request(dmrt_pkg::req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		shadow.apply_request(r);
		@(negedge clk);
	endtask

	task automatic offer(logic op, logic [63:0] key, logic [7:0] depth,
			logic [63:0] count);
		dmrt_pkg::req_t r;
		r.operation    = op;
		r.key_hash     = key;
		r.search_depth = depth;
		r.store_count  = count;
		if (op == dmrt_pkg::OP_STORE) begin
			stored_keys   = {stored_keys, key};
			stored_depths = {stored_depths, depth};
			if (stored_keys.size() > 48) begin
				void'(stored_keys.pop_front());
				void'(stored_depths.pop_front());
			end
		end
		send_request(r);
	endtask

	// Sender pause: nothing offered until every expected response is back.
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (shadow.pending() != 0);
	endtask

	// Mostly probes of recently stored keys (exact, wrong depth, or another
	// key sharing the slot), the rest stores: fresh keys, keys crowded into a
	// few slots, and keys that evict a live entry.
	task automatic random_request();
		logic [63:0] key;
		logic [63:0] flip;
		logic [7:0]  depth;
		int          pick;
		int          sel;
		key   = rand64();
		depth = 8'($urandom_range(0, 255));
		sel   = $urandom_range(0, 99);
		if (stored_keys.size() != 0) begin
			pick = $urandom_range(0, stored_keys.size() - 1);
			flip = rand64() & ~SLOT_MASK;
			if (flip == '0)
				flip = 64'h1 << 63;
		end
		if (stored_keys.size() == 0 || sel < 35) begin
			case ($urandom_range(0, 3))
				2: key[INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(0, 15));
				3: if (stored_keys.size() != 0)
					key = stored_keys[pick] ^ flip;
				default: ;
			endcase
			offer(dmrt_pkg::OP_STORE, key, depth, rand64());
		end else if (sel < 80) begin
			offer(dmrt_pkg::OP_PROBE, stored_keys[pick], stored_depths[pick], rand64());
		end else if (sel < 90) begin
			depth = stored_depths[pick] ^ (8'h1 << $urandom_range(0, 7));
			offer(dmrt_pkg::OP_PROBE, stored_keys[pick], depth, rand64());
		end else begin
			offer(dmrt_pkg::OP_PROBE, stored_keys[pick] ^ flip, stored_depths[pick],
				rand64());
		end
	endtask

	initial begin
		int burst_left;
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		rsp_stall       = 1'b0;
		hold_off_ask    = 1'b0;
		hold_off_active = 1'b0;
		cycle_count     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, hits and misses of each kind, slot
		// collision and replacement, back-to-back store then probe. The first
		// transfer waits out the clearing sweep by itself.
		offer(dmrt_pkg::OP_PROBE, 64'h123, 8'd3, 64'h0);        // never written
		offer(dmrt_pkg::OP_STORE, 64'h0, 8'd0, 64'h0);
		offer(dmrt_pkg::OP_PROBE, 64'h0, 8'd0, 64'h0);
		offer(dmrt_pkg::OP_STORE, '1, 8'd255, '1);
		offer(dmrt_pkg::OP_PROBE, '1, 8'd255, 64'h0);
		offer(dmrt_pkg::OP_PROBE, '1, 8'd254, 64'h0);           // depth differs
		offer(dmrt_pkg::OP_PROBE, 64'h7FFF_FFFF_FFFF_FFFF, 8'd255, 64'h0); // key differs
		offer(dmrt_pkg::OP_STORE, 64'h7FFF_FFFF_FFFF_FFFF, 8'd255,
			64'h0123_4567_89AB_CDEF);
		offer(dmrt_pkg::OP_PROBE, '1, 8'd255, 64'h0);           // evicted
		offer(dmrt_pkg::OP_PROBE, 64'h7FFF_FFFF_FFFF_FFFF, 8'd255, '1); // count ignored
		offer(dmrt_pkg::OP_STORE, 64'h0, 8'd7, 64'd5);          // same key, new depth
		offer(dmrt_pkg::OP_PROBE, 64'h0, 8'd0, 64'h0);
		offer(dmrt_pkg::OP_PROBE, 64'h0, 8'd7, 64'h0);
		offer(dmrt_pkg::OP_STORE, 64'hA5A5_5A5A_C3C3_3C3C, 8'h5A,
			64'h8000_0000_0000_0001);
		offer(dmrt_pkg::OP_PROBE, 64'hA5A5_5A5A_C3C3_3C3C, 8'h5A, 64'h0);
		offer(dmrt_pkg::OP_PROBE, 64'hA5A5_5A5A_C3C3_3C3C, 8'hA5, 64'h0);
		offer(dmrt_pkg::OP_STORE, 64'h5A5A_A5A5_3C3C_C3C3, 8'hA5,
			64'h7FFF_FFFF_FFFF_FFFE);
		offer(dmrt_pkg::OP_PROBE, 64'h5A5A_A5A5_3C3C_C3C3, 8'hA5, 64'h0);
		offer(dmrt_pkg::OP_PROBE, 64'h5A5A_A5A5_3C3C_C3C3 ^ (64'h1 << INDEX_BITS), 8'hA5,
			64'h0);
		offer(dmrt_pkg::OP_STORE, 64'h0, 8'd0, '1);             // overwrite in place
		offer(dmrt_pkg::OP_PROBE, 64'h0, 8'd0, 64'h0);
		drain();

		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 400)
				hold_off_ask = 1'b1;
			if (n == 1000)
				drain();
			if (burst_left == 0) begin
				// One burst in six is long and gapless.
				if ($urandom_range(0, 5) == 0)
					burst_left = 200;
				else
					burst_left = $urandom_range(1, 40);
				if (!hold_off_ask && !hold_off_active) begin
					req_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
				end
			end
			burst_left--;
			random_request();
		end

		drain();
		repeat (8) @(posedge clk);
		if (shadow.failures == 0 && shadow.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
